// ===== sv/mme_pkg.sv =====
`default_nettype none
package mme_pkg;

    // Field widths of the item and result channels.
    localparam int OPCODE_W  = 2;
    localparam int COORD_W   = 3;
    localparam int VALUE_W   = 16;
    localparam int MUL_W     = 2 * VALUE_W;
    localparam int PROD_W    = 35;
    localparam int DIM_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Depth of the result queue; the sequencer holds back new result elements
    // so that everything in flight always fits in it.
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // Item opcodes.
    localparam logic [OPCODE_W-1:0] OP_WR_A  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WR_B  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_START = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    // Bookkeeping that travels with one store read through the datapath.
    typedef struct packed {
        logic               first;
        logic               fin;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } mme_tag_t;

    // One finished result element.
    typedef struct packed {
        logic [COORD_W-1:0]       row;
        logic [COORD_W-1:0]       col;
        logic signed [PROD_W-1:0] product;
        logic                     last;
    } mme_result_t;

endpackage
`default_nettype wire

// ===== sv/mme_store.sv =====
`default_nettype none
module mme_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic                                 aclk,
    input  wire logic                                 we,
    input  wire logic [ADDR_W-1:0]                    waddr,
    input  wire logic signed [mme_pkg::VALUE_W-1:0]   wdata,
    input  wire logic [ADDR_W-1:0]                    raddr,
    output logic signed [mme_pkg::VALUE_W-1:0]        rdata
);

    logic signed [mme_pkg::VALUE_W-1:0] mem [DEPTH];

    // Single write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Single read port with registered data.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== sv/mme_seq.sv =====
`default_nettype none
module mme_seq #(
    parameter int MAX_DIM = 8,
    parameter int IDX_W   = 3,
    parameter int ADDR_W  = 6
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [mme_pkg::DIM_W-1:0]     nr,
    input  wire logic [mme_pkg::DIM_W-1:0]     nk,
    input  wire logic [mme_pkg::DIM_W-1:0]     nc,
    input  wire logic                          pop,
    output logic                               busy,
    output logic                               issue,
    output logic [ADDR_W-1:0]                  addr_a,
    output logic [ADDR_W-1:0]                  addr_b,
    output mme_pkg::mme_tag_t                  tag
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                       state_reg, state_next;
    logic [IDX_W-1:0]           i_reg, i_next;
    logic [IDX_W-1:0]           j_reg, j_next;
    logic [IDX_W-1:0]           k_reg, k_next;
    logic [mme_pkg::QCNT_W-1:0] outst_reg, outst_next;
    logic                       k_first, k_last, j_last, i_last, take;

    assign k_first = (k_reg == '0);
    assign k_last  = (mme_pkg::DIM_W'(k_reg) == nk - 1'b1);
    assign j_last  = (mme_pkg::DIM_W'(j_reg) == nc - 1'b1);
    assign i_last  = (mme_pkg::DIM_W'(i_reg) == nr - 1'b1);

    // A new result element starts only when the result queue has room for it.
    assign issue = (state_reg == ST_RUN) &&
                   !(k_first && outst_reg == mme_pkg::QCNT_W'(mme_pkg::QDEPTH));
    assign busy  = (state_reg == ST_RUN);
    assign take  = issue && k_first;

    // Row-major store addresses: A at (i, k), B at (k, j).
    assign addr_a = ADDR_W'(i_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(k_reg);
    assign addr_b = ADDR_W'(k_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(j_reg);

    always_comb begin
        tag.first = k_first;
        tag.fin   = k_last;
        tag.row   = mme_pkg::COORD_W'(i_reg);
        tag.col   = mme_pkg::COORD_W'(j_reg);
        tag.last  = i_last && j_last;
    end

    // Walk k innermost, then j, then i.
    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    if (k_last) begin
                        k_next = '0;
                        if (j_last) begin
                            j_next = '0;
                            if (i_last) begin
                                i_next     = '0;
                                state_next = ST_IDLE;
                            end else begin
                                i_next = i_reg + 1'b1;
                            end
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result elements started and not yet taken from the queue.
    always_comb begin
        outst_next = outst_reg + mme_pkg::QCNT_W'(take) - mme_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            outst_reg <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            outst_reg <= outst_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/mme_mac.sv =====
`default_nettype none
module mme_mac (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                issue,
    input  wire mme_pkg::mme_tag_t                   tag,
    input  wire logic signed [mme_pkg::VALUE_W-1:0]  rdata_a,
    input  wire logic signed [mme_pkg::VALUE_W-1:0]  rdata_b,
    output logic                                     res_valid,
    output mme_pkg::mme_result_t                     res
);

    logic                                   v1_reg, v2_reg, res_valid_reg;
    mme_pkg::mme_tag_t                      tag1_reg, tag2_reg;
    logic signed [mme_pkg::MUL_W-1:0]       mul_reg;
    logic signed [mme_pkg::PROD_W-1:0]      acc_reg, acc_next;
    mme_pkg::mme_result_t                   res_reg;

    // Control bits follow the store read, then the multiply.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            res_valid_reg <= v2_reg && tag2_reg.fin;
        end
    end

    // Multiply stage; the store data arrives in the cycle after the tag.
    always_ff @(posedge aclk) begin
        tag1_reg <= tag;
        tag2_reg <= tag1_reg;
        mul_reg  <= rdata_a * rdata_b;
    end

    // Accumulate; the first term of a dot product restarts the sum.
    always_comb begin
        if (tag2_reg.first) begin
            acc_next = mme_pkg::PROD_W'(mul_reg);
        end else begin
            acc_next = acc_reg + mme_pkg::PROD_W'(mul_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (v2_reg) begin
            acc_reg         <= acc_next;
            res_reg.row     <= tag2_reg.row;
            res_reg.col     <= tag2_reg.col;
            res_reg.last    <= tag2_reg.last;
            res_reg.product <= acc_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire

// ===== sv/matrix_multiply_engine_core.sv =====
`default_nettype none
// Matrix multiply C = A x B on signed Q8.8 elements, with exact signed Q19.16
// results. Write items (one per cycle while no walk runs) fill the A and B stores
// by row and column; a start item walks the result in row-major order, issuing
// one multiply-accumulate per cycle while the four-entry result queue has room,
// because each store has a single read port. A start therefore keeps s_ready low
// until all rows_a * cols_b * inner_dim products are issued. Dimension registers
// are clamped to 1..MAX_DIM when written; the user must change them only while
// the block is idle, which the block itself does not enforce.
module matrix_multiply_engine_core #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_we,
    input  wire logic [mme_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [mme_pkg::DIM_W-1:0]             cfg_wdata,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [mme_pkg::OPCODE_W-1:0]          s_opcode,
    input  wire logic [mme_pkg::COORD_W-1:0]           s_row,
    input  wire logic [mme_pkg::COORD_W-1:0]           s_col,
    input  wire logic signed [mme_pkg::VALUE_W-1:0]    s_value,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [mme_pkg::COORD_W-1:0]                m_out_row,
    output logic [mme_pkg::COORD_W-1:0]                m_out_col,
    output logic signed [mme_pkg::PROD_W-1:0]          m_product,
    output logic                                       m_last
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [mme_pkg::DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg, dim_clamped;
    logic                      s_take, in_range, we_a, we_b, start, busy, pop;
    logic [ADDR_W-1:0]         waddr, addr_a, addr_b;
    logic signed [mme_pkg::VALUE_W-1:0] rdata_a, rdata_b;
    logic                      issue, res_valid;
    mme_pkg::mme_tag_t         tag;
    mme_pkg::mme_result_t      res;

    // Dimension registers hold values already clamped to 1..MAX_DIM.
    always_comb begin
        if (cfg_wdata == '0) begin
            dim_clamped = mme_pkg::DIM_W'(1);
        end else if (cfg_wdata > mme_pkg::DIM_W'(MAX_DIM)) begin
            dim_clamped = mme_pkg::DIM_W'(MAX_DIM);
        end else begin
            dim_clamped = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg    <= mme_pkg::DIM_W'(MAX_DIM);
            inner_dim_reg <= mme_pkg::DIM_W'(MAX_DIM);
            cols_b_reg    <= mme_pkg::DIM_W'(MAX_DIM);
        end else if (cfg_we) begin
            case (cfg_index)
                mme_pkg::CFG_ROWS_A:    rows_a_reg    <= dim_clamped;
                mme_pkg::CFG_INNER_DIM: inner_dim_reg <= dim_clamped;
                mme_pkg::CFG_COLS_B:    cols_b_reg    <= dim_clamped;
                default: ;
            endcase
        end
    end

    // Item decode. Items are held off while a walk reads the stores.
    assign s_ready  = !busy;
    assign s_take   = s_valid && s_ready;
    assign in_range = ({1'b0, s_row} < mme_pkg::DIM_W'(MAX_DIM)) &&
                      ({1'b0, s_col} < mme_pkg::DIM_W'(MAX_DIM));
    assign we_a     = s_take && in_range && (s_opcode == mme_pkg::OP_WR_A);
    assign we_b     = s_take && in_range && (s_opcode == mme_pkg::OP_WR_B);
    assign start    = s_take && (s_opcode == mme_pkg::OP_START);
    assign waddr    = ADDR_W'(IDX_W'(s_row)) * ADDR_W'(MAX_DIM) + ADDR_W'(IDX_W'(s_col));

    mme_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (s_value),
        .raddr (addr_a),
        .rdata (rdata_a)
    );

    mme_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (s_value),
        .raddr (addr_b),
        .rdata (rdata_b)
    );

    mme_seq #(.MAX_DIM(MAX_DIM), .IDX_W(IDX_W), .ADDR_W(ADDR_W)) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .nr      (rows_a_reg),
        .nk      (inner_dim_reg),
        .nc      (cols_b_reg),
        .pop     (pop),
        .busy    (busy),
        .issue   (issue),
        .addr_a  (addr_a),
        .addr_b  (addr_b),
        .tag     (tag)
    );

    mme_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (issue),
        .tag       (tag),
        .rdata_a   (rdata_a),
        .rdata_b   (rdata_b),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result queue; the sequencer guarantees it never overflows.
    mme_pkg::mme_result_t       q_mem [mme_pkg::QDEPTH];
    logic [mme_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [mme_pkg::QCNT_W-1:0] q_cnt_reg;
    mme_pkg::mme_result_t       q_head;

    assign pop = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            q_mem[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end else begin
            if (res_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            q_cnt_reg <= q_cnt_reg + mme_pkg::QCNT_W'(res_valid) - mme_pkg::QCNT_W'(pop);
        end
    end

    assign q_head    = q_mem[rd_ptr_reg];
    assign m_valid   = (q_cnt_reg != '0);
    assign m_out_row = q_head.row;
    assign m_out_col = q_head.col;
    assign m_product = q_head.product;
    assign m_last    = q_head.last;

endmodule
`default_nettype wire

// ===== sv/mme_checker.sv =====
`default_nettype none
module mme_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    input  wire logic                                s_ready,
    input  wire logic [mme_pkg::OPCODE_W-1:0]        s_opcode,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic [mme_pkg::COORD_W-1:0]         m_out_row,
    input  wire logic [mme_pkg::COORD_W-1:0]         m_out_col,
    input  wire logic signed [mme_pkg::PROD_W-1:0]   m_product,
    input  wire logic                                m_last
);

    // A stalled result item holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_row) && $stable(m_out_col) &&
                                 $stable(m_product) && $stable(m_last))
        else $error("result item changed while stalled");

    // A start item begins a walk, which holds off the input channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_opcode == mme_pkg::OP_START |=> !s_ready)
        else $error("input still ready after a start item");

    // Element writes never block the next item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready &&
        (s_opcode == mme_pkg::OP_WR_A || s_opcode == mme_pkg::OP_WR_B) |=> s_ready)
        else $error("input blocked after an element write");

    // The block comes out of reset ready and with no results pending.
    assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not idle after reset");

endmodule

bind matrix_multiply_engine_core mme_checker u_mme_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_opcode  (s_opcode),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_out_row (m_out_row),
    .m_out_col (m_out_col),
    .m_product (m_product),
    .m_last    (m_last)
);
`default_nettype wire
